FILE: rtl/core/abh_pkg.sv
`default_nettype none
package abh_pkg;

    localparam int unsigned LANES       = 4;
    localparam int unsigned BLOCK_WORDS = 8;
    localparam int unsigned WORD_W      = 64;

    localparam logic [WORD_W-1:0] INIT_A = 64'h6d6574615f6d6172;
    localparam logic [WORD_W-1:0] INIT_B = 64'h7465735f7169735f;
    localparam logic [WORD_W-1:0] INIT_C = 64'h6e69755f4d654f6d;
    localparam logic [WORD_W-1:0] INIT_D = 64'h646f6d5f656e6f6d;

    localparam int unsigned ROT_0 = 13;
    localparam int unsigned ROT_1 = 16;
    localparam int unsigned ROT_2 = 21;
    localparam int unsigned ROT_3 = 17;

    // input kind codes
    localparam logic [1:0] KIND_START  = 2'd0;
    localparam logic [1:0] KIND_DATA   = 2'd1;
    localparam logic [1:0] KIND_FINISH = 2'd2;

    typedef enum logic [1:0] {
        CMD_START  = 2'd0,
        CMD_MIX    = 2'd1,
        CMD_FINISH = 2'd2
    } t_cmd;

    typedef logic [BLOCK_WORDS-1:0][WORD_W-1:0] t_block;
    typedef logic [LANES-1:0][WORD_W-1:0]       t_lanes;

    typedef struct packed {
        t_cmd   cmd;
        t_block words;
    } t_q_entry;

    localparam int unsigned Q_ENTRY_W = $bits(t_q_entry);

endpackage
`default_nettype wire

FILE: rtl/core/abh_front.sv
`default_nettype none
module abh_front
    import abh_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [1:0]        i_kind,
    input  wire logic [WORD_W-1:0] i_data_word,
    output logic                   o_push_valid,
    output t_q_entry               o_push_entry,
    input  wire logic              i_push_ready
);

    logic [2:0]            r_count;
    logic [2:0]            n_count;
    logic [WORD_W-1:0]     r_buf [BLOCK_WORDS-1];
    logic                  accept;

    assign o_ready = i_push_ready;
    assign accept  = i_valid && i_push_ready;

    always_comb begin
        o_push_valid       = 1'b0;
        o_push_entry.cmd   = CMD_MIX;
        o_push_entry.words = '0;
        n_count            = r_count;
        for (int w = 0; w < BLOCK_WORDS - 1; w++) begin
            o_push_entry.words[w] = r_buf[w];
        end
        o_push_entry.words[BLOCK_WORDS-1] = i_data_word;
        if (accept) begin
            unique case (i_kind)
                KIND_START: begin
                    o_push_valid     = 1'b1;
                    o_push_entry.cmd = CMD_START;
                    n_count          = '0;
                end
                KIND_DATA: begin
                    n_count = 3'(r_count + 3'd1);
                    if (r_count == 3'(BLOCK_WORDS - 1)) begin
                        o_push_valid     = 1'b1;
                        o_push_entry.cmd = CMD_MIX;
                    end
                end
                KIND_FINISH: begin
                    o_push_valid     = 1'b1;
                    o_push_entry.cmd = CMD_FINISH;
                end
                default: begin
                    // unused kind, dropped
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // gather words of the current block, the last one goes straight to the queue
    always_ff @(posedge i_clk) begin
        if (accept && i_kind == KIND_DATA && r_count != 3'(BLOCK_WORDS - 1)) begin
            r_buf[r_count] <= i_data_word;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/abh_queue.sv
`default_nettype none
module abh_queue
    import abh_pkg::*;
#(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push_valid,
    output logic                  o_push_ready,
    input  wire logic [WIDTH-1:0] i_push_data,
    output logic                  o_pop_valid,
    input  wire logic             i_pop_ready,
    output logic [WIDTH-1:0]      o_pop_data
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             push;
    logic             pop;

    assign o_push_ready = (r_count != CNT_W'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(r_wr_ptr + 1'b1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(r_rd_ptr + 1'b1);
            end
            if (push && !pop) begin
                r_count <= CNT_W'(r_count + 1'b1);
            end else if (pop && !push) begin
                r_count <= CNT_W'(r_count - 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/abh_back.sv
`default_nettype none
module abh_back
    import abh_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_pop_valid,
    input  wire t_q_entry          i_pop_entry,
    output logic                   o_pop_ready,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [WORD_W-1:0]      o_digest_word,
    output logic                   o_digest_last
);

    t_lanes            r_va, r_vb, r_vc, r_vd;
    t_lanes            n_va, n_vb, n_vc, n_vd;
    logic [2:0]        r_step;
    logic [2:0]        n_step;
    logic              r_out_valid;
    logic [WORD_W-1:0] r_out_word;
    logic              r_out_last;
    logic              out_load;
    logic              load_ok;
    logic [WORD_W-1:0] out_word;

    function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x,
                                               input int unsigned r);
        return (x << r) | (x >> (WORD_W - r));
    endfunction

    assign load_ok = !r_out_valid || i_ready;

    always_comb begin
        logic [WORD_W-1:0] a, b, c, d;
        n_va        = r_va;
        n_vb        = r_vb;
        n_vc        = r_vc;
        n_vd        = r_vd;
        n_step      = r_step;
        o_pop_ready = 1'b0;
        out_load    = 1'b0;
        out_word    = r_va[0];
        a = '0; b = '0; c = '0; d = '0;
        if (i_pop_valid) begin
            unique case (i_pop_entry.cmd)
                CMD_START: begin
                    for (int l = 0; l < LANES; l++) begin
                        n_va[l] = INIT_A;
                        n_vb[l] = INIT_B;
                        n_vc[l] = INIT_C;
                        n_vd[l] = INIT_D;
                    end
                    n_step      = '0;
                    o_pop_ready = 1'b1;
                end
                CMD_MIX: begin
                    // one add-rotate-xor step per cycle on all four lanes
                    for (int l = 0; l < LANES; l++) begin
                        a = r_va[l];
                        b = r_vb[l];
                        c = r_vc[l];
                        d = r_vd[l];
                        if (r_step == 3'd0) begin
                            a = a ^ i_pop_entry.words[l];
                            b = b ^ i_pop_entry.words[l+LANES];
                        end
                        unique case (r_step[1:0])
                            2'd0: begin
                                a = a + b;
                                b = rotl(b, ROT_0) ^ a;
                            end
                            2'd1: begin
                                c = c + d;
                                d = rotl(d, ROT_1) ^ c;
                            end
                            2'd2: begin
                                a = a + d;
                                d = rotl(d, ROT_2) ^ a;
                            end
                            2'd3: begin
                                c = c + b;
                                b = rotl(b, ROT_3) ^ c;
                            end
                            default: ;
                        endcase
                        if (r_step == 3'd7) begin
                            a = a ^ i_pop_entry.words[l];
                            b = b ^ i_pop_entry.words[l+LANES];
                        end
                        n_va[l] = a;
                        n_vb[l] = b;
                        n_vc[l] = c;
                        n_vd[l] = d;
                    end
                    n_step = 3'(r_step + 3'd1);
                    if (r_step == 3'd7) begin
                        o_pop_ready = 1'b1;
                    end
                end
                CMD_FINISH: begin
                    if (load_ok) begin
                        out_load = 1'b1;
                        unique case (r_step[1:0])
                            2'd0:    out_word = r_va[0];
                            2'd1:    out_word = r_va[1];
                            2'd2:    out_word = r_vb[0];
                            default: out_word = r_vb[1];
                        endcase
                        n_step = (r_step[1:0] == 2'd3) ? '0 : 3'(r_step + 3'd1);
                        if (r_step[1:0] == 2'd3) begin
                            o_pop_ready = 1'b1;
                        end
                    end
                end
                default: begin
                    o_pop_ready = 1'b1;
                    n_step      = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < LANES; l++) begin
                r_va[l] <= INIT_A;
                r_vb[l] <= INIT_B;
                r_vc[l] <= INIT_C;
                r_vd[l] <= INIT_D;
            end
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_va   <= n_va;
            r_vb   <= n_vb;
            r_vc   <= n_vc;
            r_vd   <= n_vd;
            r_step <= n_step;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_word <= out_word;
            r_out_last <= (r_step[1:0] == 2'd3);
        end
    end

    assign o_valid       = r_out_valid;
    assign o_digest_word = r_out_word;
    assign o_digest_last = r_out_last;

endmodule
`default_nettype wire

FILE: rtl/core/arx_block_hash_absorb_top.sv
// arx block hash absorber
//
// input channel (i_valid / o_ready): one transaction per cycle carries i_kind and
// i_data_word. kind start reloads the initial vectors, kind data adds one
// little-endian 64-bit word to the current 8-word block, kind finish asks for
// the digest, kind 3 is taken and dropped.
// output channel (o_valid / i_ready): four transactions per finish, digest words
// a0, a1, b0, b1, o_digest_last high on the fourth.
//
// the front gathers words and pushes start, full-block mix and finish commands
// into a short command queue; the back runs them in order. a block mix runs
// one add-rotate-xor step of all four lanes per cycle, as many steps as the
// block has words, so data words stream at one per cycle sustained. digest
// words follow the finish through the queue and the output register, one per
// cycle while i_ready is high, each block mix queued ahead holding them back.
// o_ready drops only when the queue is full. a stalled receiver holds the
// output register and the finish command at the queue head; the front keeps
// taking transactions until the queue fills.
// reset (synchronous, active low) loads the initial vectors, clears the word
// count, empties the queue and drops any pending digest word.
`default_nettype none
module arx_block_hash_absorb_top
    import abh_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [1:0]        i_kind,
    input  wire logic [WORD_W-1:0] i_data_word,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [WORD_W-1:0]      o_digest_word,
    output logic                   o_digest_last
);

    // front to queue
    logic                 push_valid;
    logic                 push_ready;
    t_q_entry             push_entry;

    // queue to back
    logic                 pop_valid;
    logic                 pop_ready;
    logic [Q_ENTRY_W-1:0] pop_bits;
    t_q_entry             pop_entry;

    assign pop_entry = t_q_entry'(pop_bits);

    abh_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_kind       (i_kind),
        .i_data_word  (i_data_word),
        .o_push_valid (push_valid),
        .o_push_entry (push_entry),
        .i_push_ready (push_ready)
    );

    // command queue, full-block words travel with the mix command
    abh_queue #(
        .WIDTH (Q_ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_data  (Q_ENTRY_W'(push_entry)),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_data   (pop_bits)
    );

    // state vectors, mixing sequencer and output register
    abh_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pop_valid   (pop_valid),
        .i_pop_entry   (pop_entry),
        .o_pop_ready   (pop_ready),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_digest_word (o_digest_word),
        .o_digest_last (o_digest_last)
    );

endmodule
`default_nettype wire

FILE: tb/abh_digest_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module abh_digest_checker
    import abh_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_in_ready,
    input  wire logic [1:0]        i_kind,
    input  wire logic [WORD_W-1:0] i_data_word,
    input  wire logic              i_out_valid,
    input  wire logic              i_out_ready,
    input  wire logic [WORD_W-1:0] i_digest_word,
    input  wire logic              i_digest_last,
    output logic [31:0]            o_mismatches = '0,
    output logic [31:0]            o_pending    = '0,
    output logic [31:0]            o_checked    = '0
);

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              last;
    } t_digest_beat;

    t_digest_beat expected_digest_q[$];
    t_digest_beat want;

    // predicted hash state
    logic [WORD_W-1:0] lane_a [LANES];
    logic [WORD_W-1:0] lane_b [LANES];
    logic [WORD_W-1:0] lane_c [LANES];
    logic [WORD_W-1:0] lane_d [LANES];
    logic [WORD_W-1:0] block_words [BLOCK_WORDS];
    logic [2:0]        words_held;

    function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x,
                                               input int unsigned r);
        return (x << r) | (x >> (WORD_W - r));
    endfunction

    task automatic reload_vectors();
        int lane;
        for (lane = 0; lane < LANES; lane++) begin
            lane_a[lane] = INIT_A;
            lane_b[lane] = INIT_B;
            lane_c[lane] = INIT_C;
            lane_d[lane] = INIT_D;
        end
        words_held = '0;
    endtask

    // two arx rounds per lane, block words folded in before and after
    task automatic absorb_block();
        logic [WORD_W-1:0] a, b, c, d;
        int lane, round;
        for (lane = 0; lane < LANES; lane++) begin
            a = lane_a[lane] ^ block_words[lane];
            b = lane_b[lane] ^ block_words[lane + LANES];
            c = lane_c[lane];
            d = lane_d[lane];
            for (round = 0; round < 2; round++) begin
                a = a + b; b = rotl(b, ROT_0) ^ a;
                c = c + d; d = rotl(d, ROT_1) ^ c;
                a = a + d; d = rotl(d, ROT_2) ^ a;
                c = c + b; b = rotl(b, ROT_3) ^ c;
            end
            lane_a[lane] = a ^ block_words[lane];
            lane_b[lane] = b ^ block_words[lane + LANES];
            lane_c[lane] = c;
            lane_d[lane] = d;
        end
    endtask

    task automatic queue_digest();
        t_digest_beat beat;
        beat.last = 1'b0;
        beat.word = lane_a[0]; expected_digest_q.push_back(beat);
        beat.word = lane_a[1]; expected_digest_q.push_back(beat);
        beat.word = lane_b[0]; expected_digest_q.push_back(beat);
        beat.last = 1'b1;
        beat.word = lane_b[1]; expected_digest_q.push_back(beat);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reload_vectors();
            expected_digest_q.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                case (i_kind)
                    KIND_START: reload_vectors();
                    KIND_DATA: begin
                        block_words[words_held] = i_data_word;
                        words_held = words_held + 3'd1;
                        if (words_held == 3'd0)
                            absorb_block();
                    end
                    KIND_FINISH: queue_digest();
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_digest_q.size() == 0) begin
                    if (o_mismatches < 10)
                        $display("%0t: digest word %h (last %b) with no finish pending",
                                 $realtime, i_digest_word, i_digest_last);
                    o_mismatches <= o_mismatches + 1;
                end else begin
                    want = expected_digest_q.pop_front();
                    o_checked <= o_checked + 1;
                    if (want.word !== i_digest_word || want.last !== i_digest_last) begin
                        if (o_mismatches < 10)
                            $display("%0t: digest mismatch, expected %h last %b, got %h last %b",
                                     $realtime, want.word, want.last,
                                     i_digest_word, i_digest_last);
                        o_mismatches <= o_mismatches + 1;
                    end
                end
            end
        end
        o_pending <= expected_digest_q.size();
    end

endmodule
`default_nettype wire

FILE: tb/tb_arx_block_hash_absorb_top.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_arx_block_hash_absorb_top;
    import abh_pkg::*;

    // kind value the block takes and drops
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int unsigned RANDOM_ITEMS = 90;
    // covers two queued block mixes plus the digest path
    localparam int unsigned SETTLE_CYCLES = 40;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_valid     = 1'b0;
    logic [1:0]        i_kind      = KIND_START;
    logic [WORD_W-1:0] i_data_word = '0;
    logic              i_ready     = 1'b0;
    wire               o_ready;
    wire               o_valid;
    wire  [WORD_W-1:0] o_digest_word;
    wire               o_digest_last;

    wire  [31:0]       mismatch_count;
    wire  [31:0]       pending_digests;
    wire  [31:0]       checked_digests;

    // idle percentages for the sending and receiving side
    int                send_idle_pct = 36;
    int                recv_idle_pct = 72;

    // counted transactions, dropped kind excluded
    int unsigned       sent_items    = 0;
    int unsigned       sent_words    = 0;
    int unsigned       sent_finishes = 0;
    int unsigned       phase_end;
    int                phase;

    arx_block_hash_absorb_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_kind        (i_kind),
        .i_data_word   (i_data_word),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_digest_word (o_digest_word),
        .o_digest_last (o_digest_last)
    );

    // watches both channels, predicts digests and compares them
    abh_digest_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_ready    (o_ready),
        .i_kind        (i_kind),
        .i_data_word   (i_data_word),
        .i_out_valid   (o_valid),
        .i_out_ready   (i_ready),
        .i_digest_word (o_digest_word),
        .i_digest_last (o_digest_last),
        .o_mismatches  (mismatch_count),
        .o_pending     (pending_digests),
        .o_checked     (checked_digests)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // receiver back-pressure, redrawn every cycle
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // words mostly random, sometimes all zeros or all ones
    function automatic logic [WORD_W-1:0] rand_word();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // present one transaction, maybe after a random gap, and hold it until taken
    task automatic send_item(input logic [1:0] kind, input logic [WORD_W-1:0] word);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        i_valid     <= 1'b1;
        i_kind      <= kind;
        i_data_word <= word;
        do @(posedge i_clk); while (!o_ready);
        if (kind != KIND_UNUSED)
            sent_items++;
        if (kind == KIND_DATA)
            sent_words++;
        if (kind == KIND_FINISH)
            sent_finishes++;
    endtask

    // hold off the sender until every digest word has come back
    task automatic drain_digests();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_digests != 0);
    endtask

    // one message: optional start, whole blocks, maybe a dangling partial
    // block, finish, sometimes a repeated finish
    task automatic send_message();
        int blocks;
        int n;
        if ($urandom_range(0, 3) != 0)
            send_item(KIND_START, rand_word());
        blocks = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 2);
        for (n = 0; n < blocks * BLOCK_WORDS; n++)
            send_item(KIND_DATA, rand_word());
        if ($urandom_range(0, 4) == 0) begin
            for (n = $urandom_range(1, BLOCK_WORDS - 1); n > 0; n--)
                send_item(KIND_DATA, rand_word());
        end
        send_item(KIND_FINISH, rand_word());
        if ($urandom_range(0, 5) == 0)
            send_item(KIND_FINISH, rand_word());
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // digest straight after reset: untouched initial vectors
        send_item(KIND_FINISH, '1);
        // one full block of edge patterns
        send_item(KIND_DATA, 64'h0000_0000_0000_0000);
        send_item(KIND_DATA, 64'hffff_ffff_ffff_ffff);
        send_item(KIND_DATA, 64'h8000_0000_0000_0000);
        send_item(KIND_DATA, 64'h0000_0000_0000_0001);
        send_item(KIND_DATA, 64'h5555_5555_5555_5555);
        send_item(KIND_DATA, 64'haaaa_aaaa_aaaa_aaaa);
        send_item(KIND_DATA, 64'h0123_4567_89ab_cdef);
        send_item(KIND_DATA, 64'hfedc_ba98_7654_3210);
        // back-to-back finishes must repeat the digest
        send_item(KIND_FINISH, '0);
        send_item(KIND_FINISH, '1);
        // dropped kind changes nothing
        send_item(KIND_UNUSED, '1);
        // partial block is left out of the digest
        send_item(KIND_DATA, 64'hdead_beef_cafe_f00d);
        send_item(KIND_DATA, 64'h0f0f_0f0f_0f0f_0f0f);
        send_item(KIND_DATA, 64'hf0f0_f0f0_f0f0_f0f0);
        send_item(KIND_FINISH, '0);
        // data after finish completes the same block in the same state
        send_item(KIND_DATA, 64'h7fff_ffff_ffff_ffff);
        send_item(KIND_DATA, 64'h0000_0000_0000_0000);
        send_item(KIND_DATA, 64'hffff_ffff_ffff_fffe);
        send_item(KIND_DATA, 64'h1111_2222_3333_4444);
        send_item(KIND_DATA, 64'h8888_9999_aaaa_bbbb);
        send_item(KIND_FINISH, '0);
        // start reloads the initial vectors
        send_item(KIND_START, '1);
        send_item(KIND_FINISH, '0);
        drain_digests();

        // random part in three idle regimes, draining at each boundary
        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin send_idle_pct = 36; recv_idle_pct = 72; end
                1: begin send_idle_pct = 72; recv_idle_pct = 36; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            phase_end = sent_items + RANDOM_ITEMS / 3;
            while (sent_items < phase_end) begin
                if ($urandom_range(0, 9) < 8)
                    send_message();
                else
                    send_item(2'($urandom_range(0, 3)), rand_word());
            end
            drain_digests();
        end

        // let any trailing block mix finish and catch stray outputs
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("sent %0d transactions: %0d data words, %0d finish requests",
                 sent_items, sent_words, sent_finishes);
        $display("checked %0d digest words, %0d failures", checked_digests,
                 mismatch_count + pending_digests);
        if (mismatch_count == 0 && pending_digests == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
`default_nettype wire
